FILE: hw/rtl/ffr_pkg.sv
// Shared types and constants of the first-fit range allocator.
// Used by the range cell, the cell chain and the top level; depends on nothing.
package ffr_pkg;

  localparam int SLOT_W   = 10;
  localparam int LEN_W    = 11;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 3;
  localparam int POOL_MAX = 1024;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROT,
    OP_UPD,
    OP_INS,
    OP_DEL
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [IDX_W-1:0]   idx;
    logic [SLOT_W-1:0]  start;
    logic [LEN_W-1:0]   len;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_B,
    S_DECIDE,
    S_OP1,
    S_OP2,
    S_OUT
  } state_t;

endpackage

FILE: hw/rtl/ffr_cell.sv
// One range entry of a table: a start slot and a length.
// Depends on ffr_pkg for the operation broadcast to every cell of the chain.
module ffr_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  ffr_pkg::op_t                op,
  input  logic [ffr_pkg::SLOT_W-1:0]  left_start,
  input  logic [ffr_pkg::LEN_W-1:0]   left_len,
  input  logic [ffr_pkg::SLOT_W-1:0]  right_start,
  input  logic [ffr_pkg::LEN_W-1:0]   right_len,
  output logic [ffr_pkg::SLOT_W-1:0]  start,
  output logic [ffr_pkg::LEN_W-1:0]   len
);
  import ffr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    case (op.kind)
      OP_ROT: begin
        start <= right_start;
        len   <= right_len;
      end
      OP_UPD: begin
        if (op.idx == MY_IDX) begin
          start <= op.start;
          len   <= op.len;
        end
      end
      OP_INS: begin
        if (MY_IDX > op.idx) begin
          start <= left_start;
          len   <= left_len;
        end else if (MY_IDX == op.idx) begin
          start <= op.start;
          len   <= op.len;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= op.idx) begin
          start <= right_start;
          len   <= right_len;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/ffr_chain.sv
// A table of ranges held as a row of cells that rotate, insert and delete together.
// Depends on ffr_pkg and ffr_cell; cell 0 is the head seen by the controller.
module ffr_chain #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  ffr_pkg::op_t                op,
  output logic [ffr_pkg::SLOT_W-1:0]  head_start,
  output logic [ffr_pkg::LEN_W-1:0]   head_len
);
  import ffr_pkg::*;

  logic [SLOT_W-1:0] st [DEPTH];
  logic [LEN_W-1:0]  ln [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [SLOT_W-1:0] ls;
    logic [LEN_W-1:0]  ll;
    if (k == 0) begin : g_first
      assign ls = '0;
      assign ll = '0;
    end else begin : g_rest
      assign ls = st[k-1];
      assign ll = ln[k-1];
    end
    ffr_cell #(.IDX(k)) u_cell (
      .clk         (clk),
      .op          (op),
      .left_start  (ls),
      .left_len    (ll),
      .right_start (st[(k+1) % DEPTH]),
      .right_len   (ln[(k+1) % DEPTH]),
      .start       (st[k]),
      .len         (ln[k])
    );
  end

  assign head_start = st[0];
  assign head_len   = ln[0];

endmodule

FILE: hw/rtl/first_fit_range_allocator.sv
// First-fit range allocator: a free table and a used table of sorted ranges over a slot pool.
// The input item carries cmd on s_axis_tuser and the run on s_axis_tdata; each item gives one
// result item with a status and the granted start slot. cfg_we with cfg_wdata sets the pool
// size and clears both tables in the same cycle.
// Each table is a chain of MAX_RANGES cells. A request rotates both chains twice through
// the head cell, once to find the fitting or holding range and once to find the insert
// position, and then applies at most two insert, delete or update steps to each chain.
// The next item is taken only once the result has moved to the output register; an item
// with a zero count skips both rotations and goes straight to the output step. Each
// rotation passes through all cells.
// The output register holds its item while m_axis_tready is low; a new item is then
// still accepted, but its result waits until the register is free.
// After reset the pool holds 1024 slots as one free range and the used table is empty;
// no clearing pass is needed.
module first_fit_range_allocator #(
  parameter int MAX_RANGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // first_slot[9:0], slot_count[20:10], zero fill
  input  logic [0:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[2:0], granted_slot[12:3], zero fill
);
  import ffr_pkg::*;

  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int RW = $clog2(MAX_RANGES + 1);
  localparam logic [RW-1:0] FULL_N = RW'(MAX_RANGES);
  localparam logic [IW-1:0] LAST_K = IW'(MAX_RANGES - 1);
  localparam logic [LEN_W-1:0] POOL_LEN = LEN_W'(POOL_MAX);

  typedef struct packed {
    op_t  op1;
    op_t  op2;
    logic needs;
    logic ins;
    logic del;
  } add_t;

  function automatic add_t plan_add(logic has_prev, logic [SLOT_W-1:0] ps,
                                    logic [LEN_W-1:0] pl, logic nf,
                                    logic [SLOT_W-1:0] ns, logic [LEN_W-1:0] nl,
                                    logic [IDX_W-1:0] pos, logic [SLOT_W-1:0] key,
                                    logic [LEN_W-1:0] cnt);
    add_t r;
    logic mp;
    logic mn;
    mp = has_prev && (({1'b0, ps} + pl) == {1'b0, key});
    mn = nf && (({2'b0, key} + {1'b0, cnt}) == {2'b0, ns});
    r = '0;
    r.needs = !mp && !mn;
    if (mp && mn) begin
      r.op1.kind  = OP_UPD;
      r.op1.idx   = pos - 1'b1;
      r.op1.start = ps;
      r.op1.len   = pl + cnt + nl;
      r.op2.kind  = OP_DEL;
      r.op2.idx   = pos;
      r.del       = 1'b1;
    end else if (mp) begin
      r.op1.kind  = OP_UPD;
      r.op1.idx   = pos - 1'b1;
      r.op1.start = ps;
      r.op1.len   = pl + cnt;
    end else if (mn) begin
      r.op1.kind  = OP_UPD;
      r.op1.idx   = pos;
      r.op1.start = key;
      r.op1.len   = nl + cnt;
    end else begin
      r.op1.kind  = OP_INS;
      r.op1.idx   = pos;
      r.op1.start = key;
      r.op1.len   = cnt;
      r.ins       = 1'b1;
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;

  logic [IW-1:0]     scan_k;
  logic [RW-1:0]     fn;
  logic [RW-1:0]     un;
  logic              cmd;
  logic [SLOT_W-1:0] req_s;
  logic [LEN_W-1:0]  req_c;

  logic              fit_found;
  logic [IW-1:0]     fit_i;
  logic [SLOT_W-1:0] fit_start;
  logic [LEN_W-1:0]  fit_len;
  logic              cont_found;
  logic [IW-1:0]     cont_i;
  logic [SLOT_W-1:0] cont_start;
  logic [LEN_W-1:0]  cont_len;

  logic [RW-1:0]     fb_pos;
  logic [SLOT_W-1:0] fb_ps;
  logic [LEN_W-1:0]  fb_pl;
  logic              fb_nf;
  logic [SLOT_W-1:0] fb_ns;
  logic [LEN_W-1:0]  fb_nl;
  logic [RW-1:0]     ub_pos;
  logic [SLOT_W-1:0] ub_ps;
  logic [LEN_W-1:0]  ub_pl;
  logic              ub_nf;
  logic [SLOT_W-1:0] ub_ns;
  logic [LEN_W-1:0]  ub_nl;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_grant;
  op_t                 fop1;
  op_t                 fop2;
  op_t                 uop1;
  op_t                 uop2;

  logic [STATUS_W-1:0] dec_status;
  logic [SLOT_W-1:0]   dec_grant;
  op_t                 dec_fop1;
  op_t                 dec_fop2;
  op_t                 dec_uop1;
  op_t                 dec_uop2;
  logic [RW-1:0]       dec_fn;
  logic [RW-1:0]       dec_un;

  op_t               f_op;
  op_t               u_op;
  logic [SLOT_W-1:0] f_head_start;
  logic [LEN_W-1:0]  f_head_len;
  logic [SLOT_W-1:0] u_head_start;
  logic [LEN_W-1:0]  u_head_len;

  logic              accept;
  logic              scan_end;
  logic              out_free;
  logic [RW-1:0]     k_ext;
  logic [SLOT_W-1:0] key;
  logic [LEN_W-1:0]  cfg_pool;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign scan_end = (scan_k == LAST_K);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign k_ext    = RW'(scan_k);
  assign key      = cmd ? req_s : fit_start;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    cfg_pool = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_pool = LEN_W'(1);
    end else if (cfg_wdata > POOL_LEN) begin
      cfg_pool = POOL_LEN;
    end
  end

  ffr_chain #(.DEPTH(MAX_RANGES)) u_free (
    .clk        (clk),
    .op         (f_op),
    .head_start (f_head_start),
    .head_len   (f_head_len)
  );

  ffr_chain #(.DEPTH(MAX_RANGES)) u_used (
    .clk        (clk),
    .op         (u_op),
    .head_start (u_head_start),
    .head_len   (u_head_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    f_op = '0;
    u_op = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tdata[20:10] == '0) ? S_OUT : S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        f_op.kind = OP_ROT;
        u_op.kind = OP_ROT;
        if (scan_end) begin
          state_next = S_SCAN_B;
        end
      end
      S_SCAN_B: begin
        f_op.kind = OP_ROT;
        u_op.kind = OP_ROT;
        if (scan_end) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_OP1;
      end
      S_OP1: begin
        f_op = fop1;
        u_op = uop1;
        state_next = S_OP2;
      end
      S_OP2: begin
        f_op = fop2;
        u_op = uop2;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (rst) begin
      f_op.kind  = OP_UPD;
      f_op.idx   = '0;
      f_op.start = '0;
      f_op.len   = POOL_LEN;
    end else if (cfg_we) begin
      f_op.kind  = OP_UPD;
      f_op.idx   = '0;
      f_op.start = '0;
      f_op.len   = cfg_pool;
    end
  end

  always_comb begin : decide
    logic [11:0] se;
    logic [11:0] ce;
    logic        split;
    add_t        fa;
    add_t        ua;
    se = {2'b0, req_s} + {1'b0, req_c};
    ce = {2'b0, cont_start} + {1'b0, cont_len};
    split = (req_s > cont_start) && (se < ce);
    fa = plan_add(fb_pos != '0, fb_ps, fb_pl, fb_nf, fb_ns, fb_nl, IDX_W'(fb_pos), req_s,
                  req_c);
    ua = plan_add(ub_pos != '0, ub_ps, ub_pl, ub_nf, ub_ns, ub_nl, IDX_W'(ub_pos),
                  fit_start, req_c);
    dec_status = ST_OK;
    dec_grant  = '0;
    dec_fop1 = '0;
    dec_fop2 = '0;
    dec_uop1 = '0;
    dec_uop2 = '0;
    dec_fn = fn;
    dec_un = un;
    if (!cmd) begin
      if (!fit_found) begin
        dec_status = ST_NO_SPACE;
      end else if (un == FULL_N && ua.needs) begin
        dec_status = ST_TABLE_FULL;
      end else begin
        dec_grant = fit_start;
        if (fit_len == req_c) begin
          dec_fop1.kind = OP_DEL;
          dec_fop1.idx  = IDX_W'(fit_i);
          dec_fn = fn - 1'b1;
        end else begin
          dec_fop1.kind  = OP_UPD;
          dec_fop1.idx   = IDX_W'(fit_i);
          dec_fop1.start = SLOT_W'({1'b0, fit_start} + req_c);
          dec_fop1.len   = fit_len - req_c;
        end
        dec_uop1 = ua.op1;
        dec_uop2 = ua.op2;
        dec_un = un + RW'(ua.ins) - RW'(ua.del);
      end
    end else begin
      if (!cont_found || se > ce) begin
        dec_status = ST_BAD_FREE;
      end else if ((split && un == FULL_N) || (fn == FULL_N && fa.needs)) begin
        dec_status = ST_TABLE_FULL;
      end else begin
        dec_uop1.idx = IDX_W'(cont_i);
        if (req_s == cont_start && se == ce) begin
          dec_uop1.kind = OP_DEL;
          dec_un = un - 1'b1;
        end else if (split) begin
          dec_uop1.kind  = OP_UPD;
          dec_uop1.start = cont_start;
          dec_uop1.len   = LEN_W'(req_s - cont_start);
          dec_uop2.kind  = OP_INS;
          dec_uop2.idx   = IDX_W'(cont_i) + 1'b1;
          dec_uop2.start = SLOT_W'(se);
          dec_uop2.len   = LEN_W'(ce - se);
          dec_un = un + 1'b1;
        end else if (req_s == cont_start) begin
          dec_uop1.kind  = OP_UPD;
          dec_uop1.start = SLOT_W'(se);
          dec_uop1.len   = cont_len - req_c;
        end else begin
          dec_uop1.kind  = OP_UPD;
          dec_uop1.start = cont_start;
          dec_uop1.len   = cont_len - req_c;
        end
        dec_fop1 = fa.op1;
        dec_fop2 = fa.op2;
        dec_fn = fn + RW'(fa.ins) - RW'(fa.del);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fn <= RW'(1);
      un <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        fn <= RW'(1);
        un <= '0;
      end else if (state == S_DECIDE) begin
        fn <= dec_fn;
        un <= dec_un;
      end
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= {3'b000, res_grant, res_status};
    end
    case (state)
      S_IDLE: begin
        cmd        <= s_axis_tuser[0];
        req_s      <= s_axis_tdata[9:0];
        req_c      <= s_axis_tdata[20:10];
        res_status <= ST_ZERO;
        res_grant  <= '0;
        scan_k     <= '0;
        fit_found  <= 1'b0;
        cont_found <= 1'b0;
        fop2       <= '0;
        uop2       <= '0;
      end
      S_SCAN_A: begin
        scan_k <= scan_end ? '0 : scan_k + 1'b1;
        fb_pos <= '0;
        fb_nf  <= 1'b0;
        ub_pos <= '0;
        ub_nf  <= 1'b0;
        if (k_ext < fn && !fit_found && f_head_len >= req_c) begin
          fit_found <= 1'b1;
          fit_i     <= scan_k;
          fit_start <= f_head_start;
          fit_len   <= f_head_len;
        end
        if (k_ext < un && !cont_found && req_s >= u_head_start &&
            ({1'b0, req_s} < ({1'b0, u_head_start} + u_head_len))) begin
          cont_found <= 1'b1;
          cont_i     <= scan_k;
          cont_start <= u_head_start;
          cont_len   <= u_head_len;
        end
      end
      S_SCAN_B: begin
        scan_k <= scan_end ? '0 : scan_k + 1'b1;
        if (k_ext < fn) begin
          if (f_head_start < req_s) begin
            fb_pos <= k_ext + 1'b1;
            fb_ps  <= f_head_start;
            fb_pl  <= f_head_len;
          end else if (!fb_nf) begin
            fb_nf <= 1'b1;
            fb_ns <= f_head_start;
            fb_nl <= f_head_len;
          end
        end
        if (k_ext < un) begin
          if (u_head_start < key) begin
            ub_pos <= k_ext + 1'b1;
            ub_ps  <= u_head_start;
            ub_pl  <= u_head_len;
          end else if (!ub_nf) begin
            ub_nf <= 1'b1;
            ub_ns <= u_head_start;
            ub_nl <= u_head_len;
          end
        end
      end
      S_DECIDE: begin
        res_status <= dec_status;
        res_grant  <= dec_grant;
        fop1 <= dec_fop1;
        fop2 <= dec_fop2;
        uop1 <= dec_uop1;
        uop2 <= dec_uop2;
      end
      default: begin
      end
    endcase
  end

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    fn <= FULL_N)
    else $error("free table count out of range");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    un <= FULL_N)
    else $error("used table count out of range");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[12:3] == '0)
    else $error("grant given with a failing status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is at work");

endmodule

FILE: test/ffr_checker.sv
// Checker for the first-fit range allocator: watches the request and result channels,
// predicts each result from its own copy of the free and used range tables, and counts
// mismatches. Depends on ffr_pkg for the status codes.
`timescale 1ns / 1ps
module ffr_checker #(
  parameter int MAX_RANGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          errors,
  output int          pending,
  output int          used_count
);
  import ffr_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   grant;
  } grant_t;

  int pool;
  int fs[MAX_RANGES+1], fl[MAX_RANGES+1], fn;
  int us[MAX_RANGES+1], ul[MAX_RANGES+1], un;
  grant_t grants_due[$];

  assign pending = grants_due.size();
  assign used_count = un;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_pool(input int v);
    pool = v;
    fs[0] = 0;
    fl[0] = v;
    fn = 1;
    un = 0;
  endtask

  function automatic int find_pos(ref int st[MAX_RANGES+1], input int n, input int s);
    int p;
    p = 0;
    while (p < n && st[p] < s) p++;
    return p;
  endfunction

  function automatic bit needs_entry(ref int st[MAX_RANGES+1], ref int ln[MAX_RANGES+1],
                                     input int n, input int s, input int c);
    int p;
    p = find_pos(st, n, s);
    return !((p > 0 && st[p-1] + ln[p-1] == s) || (p < n && s + c == st[p]));
  endfunction

  task automatic tbl_ins(ref int st[MAX_RANGES+1], ref int ln[MAX_RANGES+1], ref int n,
                         input int p, input int s, input int c);
    for (int k = n; k > p; k--) begin
      st[k] = st[k-1];
      ln[k] = ln[k-1];
    end
    st[p] = s;
    ln[p] = c;
    n++;
  endtask

  task automatic tbl_del(ref int st[MAX_RANGES+1], ref int ln[MAX_RANGES+1], ref int n,
                         input int p);
    for (int k = p; k + 1 < n; k++) begin
      st[k] = st[k+1];
      ln[k] = ln[k+1];
    end
    n--;
  endtask

  task automatic merge_in(ref int st[MAX_RANGES+1], ref int ln[MAX_RANGES+1], ref int n,
                          input int s, input int c);
    int p;
    bit mp, mn;
    p = find_pos(st, n, s);
    mp = p > 0 && st[p-1] + ln[p-1] == s;
    mn = p < n && s + c == st[p];
    if (mp && mn) begin
      ln[p-1] += c + ln[p];
      tbl_del(st, ln, n, p);
    end else if (mp) begin
      ln[p-1] += c;
    end else if (mn) begin
      st[p] -= c;
      ln[p] += c;
    end else begin
      tbl_ins(st, ln, n, p, s, c);
    end
  endtask

  task automatic carve_out(ref int st[MAX_RANGES+1], ref int ln[MAX_RANGES+1], ref int n,
                           input int i, input int s, input int c);
    int lo, hi;
    lo = s - st[i];
    hi = st[i] + ln[i] - (s + c);
    if (lo == 0 && hi == 0) begin
      tbl_del(st, ln, n, i);
    end else if (lo > 0 && hi > 0) begin
      ln[i] = lo;
      tbl_ins(st, ln, n, i + 1, s + c, hi);
    end else if (lo == 0) begin
      st[i] += c;
      ln[i] -= c;
    end else begin
      ln[i] -= c;
    end
  endtask

  task automatic predict_grant(input bit is_free, input int s, input int c);
    grant_t g;
    int i;
    bit split;
    g.status = ST_OK;
    g.grant = '0;
    if (c == 0) begin
      g.status = ST_ZERO;
    end else if (!is_free) begin
      i = 0;
      while (i < fn && fl[i] < c) i++;
      if (i >= fn) begin
        g.status = ST_NO_SPACE;
      end else if (un >= MAX_RANGES && needs_entry(us, ul, un, fs[i], c)) begin
        g.status = ST_TABLE_FULL;
      end else begin
        g.grant = SLOT_W'(fs[i]);
        carve_out(fs, fl, fn, i, fs[i], c);
        merge_in(us, ul, un, int'(g.grant), c);
      end
    end else begin
      i = 0;
      while (i < un && !(s >= us[i] && s < us[i] + ul[i])) i++;
      if (i >= un || s + c > us[i] + ul[i]) begin
        g.status = ST_BAD_FREE;
      end else begin
        split = s > us[i] && s + c < us[i] + ul[i];
        if ((split && un >= MAX_RANGES) ||
            (fn >= MAX_RANGES && needs_entry(fs, fl, fn, s, c))) begin
          g.status = ST_TABLE_FULL;
        end else begin
          carve_out(us, ul, un, i, s, c);
          merge_in(fs, fl, fn, s, c);
        end
      end
    end
    grants_due.push_back(g);
  endtask

  initial begin
    errors = 0;
    clear_pool(POOL_MAX);
  end

  always @(posedge clk) begin
    grant_t want, got;
    if (rst) begin
      clear_pool(POOL_MAX);
    end else begin
      if (cfg_we) begin
        clear_pool(cfg_wdata == 0 ? 1 : (cfg_wdata > POOL_MAX ? POOL_MAX : cfg_wdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.grant = m_axis_tdata[12:3];
        if (grants_due.size() == 0) begin
          report($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = grants_due.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.grant != want.grant)
            report($sformatf("granted_slot %0d, expected %0d", got.grant, want.grant));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_grant(s_axis_tuser[0], s_axis_tdata[9:0], s_axis_tdata[20:10]);
    end
  end
endmodule

FILE: test/tb_first_fit_range_allocator.sv
// Top of the allocator testbench: drives reset, pool size writes and allocate/free requests
// with random gaps and stalls, and gives the verdict. Depends on ffr_checker and the block.
`timescale 1ns / 1ps
module tb_first_fit_range_allocator;
  import ffr_pkg::*;

  logic clk, rst, cfg_we;
  logic [10:0] cfg_wdata;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic [15:0] m_axis_tdata;
  int errors, pending, used_count;
  int cycles;
  int live_s[$], live_c[$];

  first_fit_range_allocator uut (.*);

  ffr_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 10000000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  initial begin
    m_axis_tready = 0;
    @(negedge clk);
    forever begin
      m_axis_tready = 1;
      repeat (gap_len()) @(negedge clk);
      m_axis_tready = 0;
      repeat ($urandom_range(0, 3) == 0 ? gap_len() : 0) @(negedge clk);
      @(negedge clk);
    end
  end

  task automatic send(input bit is_free, input int s, input int c);
    s_axis_tvalid <= 1;
    s_axis_tuser <= is_free;
    s_axis_tdata <= {3'b0, c[10:0], s[9:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_pool(input int v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= 11'(v);
    @(negedge clk);
    cfg_we <= 0;
    live_s.delete();
    live_c.delete();
  endtask

  task automatic alloc_req(input int c);
    send(0, $urandom_range(0, 1023), c);
  endtask

  task automatic run_random(input int n, input int maxc);
    int s, c;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          c = $urandom_range(1, maxc);
          live_s.push_back(-1);
          live_c.push_back(c);
          alloc_req(c);
        end
        4, 5, 6, 7: begin
          if (used_count > 0 && $urandom_range(0, 3) != 0) begin
            s = $urandom_range(0, 1023);
            c = $urandom_range(1, 8);
          end else begin
            s = $urandom_range(0, 1023);
            c = $urandom_range(1, 2047);
          end
          if ($urandom_range(0, 1)) begin
            s = s & ~3;
            c = $urandom_range(1, 4);
          end
          send(1, s, c);
        end
        8: send($urandom_range(0, 1), $urandom_range(0, 1023), 0);
        default: send($urandom_range(0, 1), $urandom_range(0, 1023),
                      $urandom_range(0, 2047));
      endcase
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    repeat (2) @(negedge clk);
    rst = 0;

    send(0, 0, 0);
    send(1, 1023, 0);
    send(0, 1023, 1024);
    send(0, 0, 1);
    send(1, 0, 1024);
    send(1, 0, 1024);
    send(0, 0, 1025);
    send(0, 0, 2047);
    send(1, 1023, 2047);
    send(0, 0, 4);
    send(0, 0, 4);
    send(0, 0, 4);
    send(1, 4, 4);
    send(1, 0, 4);
    send(1, 8, 4);
    send(1, 1023, 1);
    set_pool(0);
    send(0, 0, 2);
    send(0, 0, 1);
    send(1, 0, 1);
    set_pool(2047);
    send(0, 0, 1024);
    send(1, 512, 1);

    // Fill the used table by freeing every other slot of a full pool, then reclaim.
    set_pool(200);
    send(0, 0, 200);
    for (int k = 1; k < 140; k += 2) send(1, k, 1);
    send(0, 0, 1);
    for (int k = 0; k < 140; k += 2) send(1, k, 1);
    drain();

    set_pool(1024);
    run_random(500, 64);
    set_pool(96);
    run_random(500, 6);
    set_pool(1);
    run_random(150, 2);
    set_pool(300);
    run_random(400, 12);
    set_pool(1024);
    run_random(350, 1024);

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/ffr_pkg.sv
hw/rtl/ffr_cell.sv
hw/rtl/ffr_chain.sv
hw/rtl/first_fit_range_allocator.sv
test/ffr_checker.sv
test/tb_first_fit_range_allocator.sv
